[sv/hkrb_pkg.sv]
// hkrb_pkg: shared types and constants for the boot keyboard report builder
`default_nettype none
package hkrb_pkg;

   // event kinds on the request channel
   localparam logic [2:0] KIND_KEY_DOWN = 3'd0;
   localparam logic [2:0] KIND_KEY_UP   = 3'd1;
   localparam logic [2:0] KIND_ALL_UP   = 3'd2;
   localparam logic [2:0] KIND_MOD_SET  = 3'd3;
   localparam logic [2:0] KIND_MOD_CLR  = 3'd4;
   localparam logic [2:0] KIND_CLICK    = 3'd5;

   // single-step operations applied to the keyboard state
   localparam logic [2:0] OP_NONE     = 3'd0;
   localparam logic [2:0] OP_KEY_DOWN = 3'd1;
   localparam logic [2:0] OP_KEY_UP   = 3'd2;
   localparam logic [2:0] OP_ALL_UP   = 3'd3;
   localparam logic [2:0] OP_MOD_SET  = 3'd4;
   localparam logic [2:0] OP_MOD_CLR  = 3'd5;

   // click phases: modifier set, key down, key up, modifier clear
   localparam logic [1:0] PH_MOD_SET  = 2'd0;
   localparam logic [1:0] PH_KEY_DOWN = 2'd1;
   localparam logic [1:0] PH_KEY_UP   = 2'd2;
   localparam logic [1:0] PH_MOD_CLR  = 2'd3;

   localparam int         REPORT_KEYS   = 6;
   localparam logic [7:0] RESERVED_BYTE = 8'h00;
   localparam logic [7:0] EMPTY_SLOT    = 8'h00;

   typedef logic [7:0] byte_type;

   // step control from the sequencer to the state logic
   typedef struct packed {
      logic       valid;
      logic [2:0] op;
      logic [7:0] code;
      logic [7:0] mask;
      logic       last;
   } step_ctl_type;

endpackage
`default_nettype wire

[sv/hkrb_if.sv]
// hkrb_if: request and response channel interfaces
`default_nettype none
interface hkrb_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] key_code;
   logic [7:0] modifier_mask;

   modport source (output valid, kind, key_code, modifier_mask, input ready);
   modport sink   (input valid, kind, key_code, modifier_mask, output ready);
endinterface

interface hkrb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] report_modifiers;
   logic [7:0] report_reserved;
   logic [7:0] report_key0;
   logic [7:0] report_key1;
   logic [7:0] report_key2;
   logic [7:0] report_key3;
   logic [7:0] report_key4;
   logic [7:0] report_key5;
   logic       last;

   modport source (output valid, report_modifiers, report_reserved, report_key0,
                   report_key1, report_key2, report_key3, report_key4,
                   report_key5, last, input ready);
   modport sink   (input valid, report_modifiers, report_reserved, report_key0,
                   report_key1, report_key2, report_key3, report_key4,
                   report_key5, last, output ready);
endinterface
`default_nettype wire

[sv/hid_keyboard_report_builder.sv]
// hid_keyboard_report_builder: top level of the boot keyboard report builder
// a request is held in the hkrb_seq request register, then its report is written to the output register
// a new request can be taken while the last step of the previous item runs; a click takes one step per phase
// a step waits while the output register holds a report that is not taken
// reset: synchronous, clears modifiers, all key slots and both valid flags
`default_nettype none
module hid_keyboard_report_builder
   import hkrb_pkg::*;
#(
   parameter int SLOT_COUNT = 6
) (
   input  wire logic clock,
   input  wire logic reset,
   hkrb_req_if.sink  req_chan,
   hkrb_rsp_if.source rsp_chan
);

   step_ctl_type ctl;
   logic         advance;
   logic         emit;
   logic [7:0]   mods_ff, mods_in;
   byte_type     slot_ff [SLOT_COUNT];
   byte_type     slot_in [SLOT_COUNT];
   logic         rsp_vld_ff, rsp_vld_in;
   logic [7:0]   rep_mods_ff;
   byte_type     rep_key_ff [REPORT_KEYS];
   logic         rep_last_ff;

   // step may run when the output register is free or being emptied
   assign advance = ctl.valid && (!rsp_vld_ff || rsp_chan.ready);

   hkrb_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .ctl      (ctl)
   );

   hkrb_step #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_step (
      .op         (ctl.op),
      .code       (ctl.code),
      .mask       (ctl.mask),
      .mods       (mods_ff),
      .slots      (slot_ff),
      .mods_next  (mods_in),
      .slots_next (slot_in),
      .emit       (emit)
   );

   // keyboard state
   always_ff @(posedge clock) begin
      if (reset) begin
         mods_ff <= 8'd0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_ff[i] <= EMPTY_SLOT;
         end
      end else if (advance) begin
         mods_ff <= mods_in;
         slot_ff <= slot_in;
      end
   end

   // output register valid
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (advance && emit) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // output report payload
   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rep_mods_ff <= mods_in;
         rep_last_ff <= ctl.last;
      end
   end

   for (genvar g = 0; g < REPORT_KEYS; g++) begin : g_key
      if (g < SLOT_COUNT) begin : g_slot
         always_ff @(posedge clock) begin
            if (advance && emit) begin
               rep_key_ff[g] <= slot_in[g];
            end
         end
      end else begin : g_none
         always_ff @(posedge clock) begin
            rep_key_ff[g] <= EMPTY_SLOT;
         end
      end
   end

   assign rsp_chan.valid            = rsp_vld_ff;
   assign rsp_chan.report_modifiers = rep_mods_ff;
   assign rsp_chan.report_reserved  = RESERVED_BYTE;
   assign rsp_chan.report_key0      = rep_key_ff[0];
   assign rsp_chan.report_key1      = rep_key_ff[1];
   assign rsp_chan.report_key2      = rep_key_ff[2];
   assign rsp_chan.report_key3      = rep_key_ff[3];
   assign rsp_chan.report_key4      = rep_key_ff[4];
   assign rsp_chan.report_key5      = rep_key_ff[5];
   assign rsp_chan.last             = rep_last_ff;

   // a held report is never overwritten by a new step
   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_chan.ready |-> !advance)
      else $error("step ran while report was stalled");

   // an accepted request is held for the step logic in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> ctl.valid)
      else $error("accepted request not registered");

   // reset leaves no modifiers set
   assert property (@(posedge clock)
      reset |=> mods_ff == 8'd0)
      else $error("modifiers not cleared by reset");

endmodule
`default_nettype wire

[sv/hkrb_step.sv]
// hkrb_step: one state update step on the modifier byte and key slots
`default_nettype none
module hkrb_step
   import hkrb_pkg::*;
#(
   parameter int SLOT_COUNT = 6
) (
   input  wire logic [2:0] op,
   input  wire logic [7:0] code,
   input  wire logic [7:0] mask,
   input  wire logic [7:0] mods,
   input  wire byte_type   slots [SLOT_COUNT],
   output logic      [7:0] mods_next,
   output byte_type        slots_next [SLOT_COUNT],
   output logic            emit
);

   // lowest empty slot and lowest matching slot
   always_comb begin
      logic found;
      found      = 1'b0;
      mods_next  = mods;
      slots_next = slots;
      emit       = 1'b0;
      unique case (op)
         OP_KEY_DOWN: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (!found && slots[i] == EMPTY_SLOT) begin
                  slots_next[i] = code;
                  found         = 1'b1;
               end
            end
            emit = found;
         end
         OP_KEY_UP: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (!found && slots[i] == code) begin
                  slots_next[i] = EMPTY_SLOT;
                  found         = 1'b1;
               end
            end
            emit = found;
         end
         OP_ALL_UP: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               slots_next[i] = EMPTY_SLOT;
            end
            emit = 1'b1;
         end
         OP_MOD_SET: begin
            mods_next = mods | mask;
            emit      = 1'b1;
         end
         OP_MOD_CLR: begin
            mods_next = mods & ~mask;
            emit      = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

[sv/hkrb_seq.sv]
// hkrb_seq: request register and click phase sequencer
`default_nettype none
module hkrb_seq
   import hkrb_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   hkrb_req_if.sink    req_chan,
   input  wire logic   advance,
   output step_ctl_type ctl
);

   logic       vld_ff,   vld_in;
   logic [1:0] phase_ff, phase_in;
   logic [2:0] kind_ff;
   logic [7:0] code_ff;
   logic [7:0] mask_ff;
   logic       done;
   logic       accept;

   // an item finishes on its only step, or on the last click phase
   assign done   = (kind_ff != KIND_CLICK) || (phase_ff == PH_MOD_CLR);
   assign req_chan.ready = !vld_ff || (advance && done);
   assign accept = req_chan.valid && req_chan.ready;

   // next control state
   always_comb begin
      vld_in   = vld_ff;
      phase_in = phase_ff;
      if (accept) begin
         vld_in   = 1'b1;
         phase_in = PH_MOD_SET;
      end else if (advance && done) begin
         vld_in = 1'b0;
      end else if (advance) begin
         phase_in = phase_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= 1'b0;
         phase_ff <= PH_MOD_SET;
      end else begin
         vld_ff   <= vld_in;
         phase_ff <= phase_in;
      end
   end

   // request payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_chan.kind;
         code_ff <= req_chan.key_code;
         mask_ff <= req_chan.modifier_mask;
      end
   end

   // operation for the current step
   always_comb begin
      logic mask_any;
      mask_any  = (mask_ff != 8'd0);
      ctl.valid = vld_ff;
      ctl.code  = code_ff;
      ctl.mask  = mask_ff;
      ctl.op    = OP_NONE;
      ctl.last  = 1'b1;
      unique case (kind_ff)
         KIND_KEY_DOWN: ctl.op = OP_KEY_DOWN;
         KIND_KEY_UP:   ctl.op = OP_KEY_UP;
         KIND_ALL_UP:   ctl.op = OP_ALL_UP;
         KIND_MOD_SET:  ctl.op = OP_MOD_SET;
         KIND_MOD_CLR:  ctl.op = OP_MOD_CLR;
         KIND_CLICK: begin
            // a successful key down is always followed by a matching key up
            ctl.last = (phase_ff == PH_MOD_CLR) || (phase_ff == PH_KEY_UP && !mask_any);
            if (mask_any || code_ff != 8'd0) begin
               unique case (phase_ff)
                  PH_MOD_SET:  ctl.op = mask_any ? OP_MOD_SET : OP_NONE;
                  PH_KEY_DOWN: ctl.op = OP_KEY_DOWN;
                  PH_KEY_UP:   ctl.op = OP_KEY_UP;
                  PH_MOD_CLR:  ctl.op = mask_any ? OP_MOD_CLR : OP_NONE;
                  default:     ctl.op = OP_NONE;
               endcase
            end
         end
         default: ctl.op = OP_NONE;
      endcase
   end

endmodule
`default_nettype wire
